### rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared constants, types and functions for quaternion to euler bins
// Holds the arctangent table, datapath widths and the beat record that
// travels down the cordic cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int TABLE_LEN          = 24;

    // cordic datapath width: operands prescaled to about 2^40, plus growth
    localparam int XY_W = 48;
    // angle width in units of 2^-32 turn, with headroom
    localparam int Z_W  = 36;

    localparam logic [Z_W-1:0] QUARTER_TURN = Z_W'(64'sd1 <<< 30);

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_ang;

    // one rotator lane; zero marks a zero vector whose angle stays zero
    typedef struct packed {
        logic zero;
        t_xy  x;
        t_xy  y;
        t_ang z;
    } t_lane;

    // atan(2^-i) in 2^-32 turn
    function automatic t_ang atan_tab(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_tab = t_ang'({1'b0, v});
        end
    endfunction

endpackage

`default_nettype wire

### rtl/quaternion_to_euler_bins_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_bins_top: unit quaternion to euler bins and levels
// Input channel takes one quaternion per beat; output channel gives roll,
// pitch and yaw as bins 0..18 and levels -50..50 for each beat.
// Fully pipelined: one beat per clock while the output is not stalled, through
// six front stages (products, operands, square term, three-stage square root
// with the quadrant fold), the chain of cordic cells, one iteration per cell,
// three lanes each, and two output stages.
// The whole pipe advances together; when the output is stalled with a beat
// waiting, the pipe freezes and o_stall is raised back to the sender only
// then, so a new beat still enters while the output register is empty or
// being drained.
// Reset (synchronous, active low) clears all valid flags; no beat is lost or
// invented. Zero vectors give angle zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_bins_top
    import qte_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire signed [COMPONENT_BITS-1:0] i_quat_w,
    input  wire signed [COMPONENT_BITS-1:0] i_quat_x,
    input  wire signed [COMPONENT_BITS-1:0] i_quat_y,
    input  wire signed [COMPONENT_BITS-1:0] i_quat_z,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [4:0]                      o_roll_bin,
    output logic [4:0]                      o_pitch_bin,
    output logic [4:0]                      o_yaw_bin,
    output logic signed [6:0]               o_pitch_level,
    output logic signed [6:0]               o_yaw_level,
    output logic signed [6:0]               o_roll_level
);

    localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic  w_en;
    logic  w_vld  [N+1];
    t_lane w_lane [N+1][3];

    // pipe moves unless a finished beat is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_vld   (w_vld[0]),
        .o_lane  (w_lane[0])
    );

    // cordic cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        qte_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_lane  (w_lane[g]),
            .o_vld   (w_vld[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    qte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_vld         (w_vld[N]),
        .i_lane        (w_lane[N]),
        .o_vld         (o_valid),
        .o_roll_bin    (o_roll_bin),
        .o_pitch_bin   (o_pitch_bin),
        .o_yaw_bin     (o_yaw_bin),
        .o_pitch_level (o_pitch_level),
        .o_yaw_level   (o_yaw_level),
        .o_roll_level  (o_roll_level)
    );

    // a held beat keeps its payload (roll bin and yaw level are checked)
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_roll_bin) && $stable(o_yaw_level)))
        else $error("held beat changed");

    // sender is stalled only behind a held beat
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without held beat");

    // bins stay in range
    a_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_bin <= 5'd18 && o_pitch_bin <= 5'd18 && o_yaw_bin <= 5'd18))
        else $error("bin out of range");

endmodule

`default_nettype wire

### rtl/qte_cell.sv
// ----------------------------------------------------------------------------
// qte_cell: one cordic vectoring iteration for three lanes
// Each cell registers its lanes and hands them to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_vld,
    input  t_lane      i_lane [3],
    output logic       o_vld,
    output t_lane      o_lane [3]
);

    localparam t_ang ANG = atan_tab(5'(STEP));

    logic  r_vld;
    t_lane r_lane [3];
    t_lane n_lane [3];

    // micro-rotation toward y = 0, zero vectors pass through
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k] = i_lane[k];
            if (!i_lane[k].zero) begin
                if (!i_lane[k].y[XY_W-1]) begin
                    n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                    n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                    n_lane[k].z = i_lane[k].z + ANG;
                end else begin
                    n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                    n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                    n_lane[k].z = i_lane[k].z - ANG;
                end
            end
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // lane payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

`default_nettype wire

### rtl/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front: quaternion products, sine clamp, square root and prescale
// Six registered stages: products, operands, square term, two partial root
// stages, then the last root bits with the quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front
    import qte_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_en,
    input  wire                             i_vld,
    input  wire signed [COMPONENT_BITS-1:0] i_w,
    input  wire signed [COMPONENT_BITS-1:0] i_x,
    input  wire signed [COMPONENT_BITS-1:0] i_y,
    input  wire signed [COMPONENT_BITS-1:0] i_z,
    output logic                            o_vld,
    output t_lane                           o_lane [3]
);

    localparam int F   = COMPONENT_BITS - 2;
    localparam int PW  = 2 * COMPONENT_BITS - F;     // floored product width
    localparam int OW  = PW + 4;                      // operand width
    localparam int SW  = 2 * F + 2;                   // square width
    localparam int RW  = F + 1;                       // root width
    localparam int PER = (RW + 2) / 3;                // root bits per stage
    localparam int PS  = 40 - F;
    localparam logic signed [OW-1:0] ONE = OW'(64'sd1 <<< F);

    // partial square root state
    typedef struct packed {
        logic [SW+1:0] rem;
        logic [RW-1:0] root;
    } t_sq;

    // stage one: floored products
    logic                 r_v1;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    function automatic logic signed [PW-1:0] mq(
        input logic signed [COMPONENT_BITS-1:0] a,
        input logic signed [COMPONENT_BITS-1:0] b);
        logic signed [2*COMPONENT_BITS-1:0] p;
        begin
            p  = a * b;
            mq = PW'(p >>> F);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= mq(i_w, i_x);
            r_yz <= mq(i_y, i_z);
            r_xx <= mq(i_x, i_x);
            r_yy <= mq(i_y, i_y);
            r_wy <= mq(i_w, i_y);
            r_zx <= mq(i_z, i_x);
            r_wz <= mq(i_w, i_z);
            r_xy <= mq(i_x, i_y);
            r_zz <= mq(i_z, i_z);
        end
    end

    // stage two: atan2 operands and clamped sine
    logic                 r_v2;
    logic signed [OW-1:0] r_ry, r_rx, r_yy2, r_yx, r_s;
    logic signed [OW-1:0] n_s;

    always_comb begin
        n_s = (OW'(r_wy) - OW'(r_zx)) <<< 1;
        if (n_s > ONE) begin
            n_s = ONE;
        end else if (n_s < -ONE) begin
            n_s = -ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ry  <= (OW'(r_wx) + OW'(r_yz)) <<< 1;
            r_rx  <= ONE - ((OW'(r_xx) + OW'(r_yy)) <<< 1);
            r_yy2 <= (OW'(r_wz) + OW'(r_xy)) <<< 1;
            r_yx  <= ONE - ((OW'(r_yy) + OW'(r_zz)) <<< 1);
            r_s   <= n_s;
        end
    end

    // stage three: square term for the cosine
    logic                 r_v3;
    logic signed [OW-1:0] r3_ry, r3_rx, r3_yy, r3_yx, r3_s;
    logic [SW-1:0]        r_rad;
    logic signed [SW-1:0] s_n;

    assign s_n = SW'(r_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ry <= r_ry;
            r3_rx <= r_rx;
            r3_yy <= r_yy2;
            r3_yx <= r_yx;
            r3_s  <= r_s;
            r_rad <= SW'((SW+1)'(1) << (2 * F)) - SW'(s_n * s_n);
        end
    end

    // integer square root, result bits top down to top - PER + 1
    function automatic t_sq sq_part(input t_sq st, input logic [SW-1:0] rad,
                                    input int top);
        t_sq           r;
        logic [SW+1:0] trial;
        begin
            r = st;
            for (int b = RW - 1; b >= 0; b--) begin
                if (b <= top && b > top - PER) begin
                    r.rem = (r.rem << 2) | (SW+2)'((rad >> (2 * b)) & SW'(3));
                    trial = (SW+2)'({r.root, 2'b01});
                    if (r.rem >= trial) begin
                        r.rem  = r.rem - trial;
                        r.root = (r.root << 1) | RW'(1);
                    end else begin
                        r.root = r.root << 1;
                    end
                end
            end
            sq_part = r;
        end
    endfunction

    // stage four: upper root bits
    logic                 r_v4;
    logic signed [OW-1:0] r4_ry, r4_rx, r4_yy, r4_yx, r4_s;
    logic [SW-1:0]        r4_rad;
    t_sq                  r4_sq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ry  <= r3_ry;
            r4_rx  <= r3_rx;
            r4_yy  <= r3_yy;
            r4_yx  <= r3_yx;
            r4_s   <= r3_s;
            r4_rad <= r_rad;
            r4_sq  <= sq_part('0, r_rad, RW - 1);
        end
    end

    // stage five: middle root bits
    logic                 r_v5;
    logic signed [OW-1:0] r5_ry, r5_rx, r5_yy, r5_yx, r5_s;
    logic [SW-1:0]        r5_rad;
    t_sq                  r5_sq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ry  <= r4_ry;
            r5_rx  <= r4_rx;
            r5_yy  <= r4_yy;
            r5_yx  <= r4_yx;
            r5_s   <= r4_s;
            r5_rad <= r4_rad;
            r5_sq  <= sq_part(r4_sq, r4_rad, RW - 1 - PER);
        end
    end

    // lower root bits give the cosine
    t_sq           n_sq;
    logic [RW-1:0] n_root;
    assign n_sq   = sq_part(r5_sq, r5_rad, RW - 1 - 2 * PER);
    assign n_root = n_sq.root;

    // quadrant fold and prescale into the first cell
    function automatic t_lane fold(input logic signed [OW-1:0] y,
                                   input logic signed [OW-1:0] x);
        t_xy   px, py;
        t_lane r;
        begin
            px     = t_xy'(x) <<< PS;
            py     = t_xy'(y) <<< PS;
            r.zero = (x == '0) && (y == '0);
            if (x < 0) begin
                if (y >= 0) begin
                    r.x = py;
                    r.y = -px;
                    r.z = QUARTER_TURN;
                end else begin
                    r.x = -py;
                    r.y = px;
                    r.z = -QUARTER_TURN;
                end
            end else begin
                r.x = px;
                r.y = py;
                r.z = '0;
            end
            fold = r;
        end
    endfunction

    t_lane r_lane [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane[0] <= fold(r5_ry, r5_rx);
            r_lane[1] <= fold(r5_s, OW'(n_root));
            r_lane[2] <= fold(r5_yy, r5_yx);
        end
    end

    // valid chain
    logic r_v6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_vld  = r_v6;
    assign o_lane = r_lane;

endmodule

`default_nettype wire

### rtl/qte_back.sv
// ----------------------------------------------------------------------------
// qte_back: angle to fraction, bins and levels
// Clamps each angle to its range, then scales by 18 and 100.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_back
    import qte_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_vld,
    input  t_lane      i_lane [3],
    output logic       o_vld,
    output logic [4:0] o_roll_bin,
    output logic [4:0] o_pitch_bin,
    output logic [4:0] o_yaw_bin,
    output logic signed [6:0] o_pitch_level,
    output logic signed [6:0] o_yaw_level,
    output logic signed [6:0] o_roll_level
);

    // clamp angle plus offset into [0, hi]
    function automatic logic [32:0] frac(input t_ang a, input logic pitch);
        logic signed [Z_W:0] v;
        logic signed [Z_W:0] hi;
        begin
            v  = (Z_W+1)'(a) + (pitch ? (Z_W+1)'(64'sd1 <<< 30) : (Z_W+1)'(64'sd1 <<< 31));
            hi = pitch ? (Z_W+1)'(64'sd1 <<< 31) : (Z_W+1)'(64'sd1 <<< 32);
            if (v < 0) begin
                frac = '0;
            end else if (v > hi) begin
                frac = 33'(hi);
            end else begin
                frac = 33'(v);
            end
        end
    endfunction

    logic        r_v1;
    logic [32:0] r_tr, r_tp, r_ty;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tr <= frac(i_lane[0].z, 1'b0);
            r_tp <= frac(i_lane[1].z, 1'b1);
            r_ty <= frac(i_lane[2].z, 1'b0);
        end
    end

    // scaled values
    logic [39:0] m18r, m18p, m18y, m100r, m100p, m100y;
    assign m18r  = 40'(r_tr) * 40'd18;
    assign m18p  = 40'(r_tp) * 40'd18;
    assign m18y  = 40'(r_ty) * 40'd18;
    assign m100r = 40'(r_tr) * 40'd100;
    assign m100p = 40'(r_tp) * 40'd100;
    assign m100y = 40'(r_ty) * 40'd100;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_roll_bin    <= m18r[36:32];
            o_pitch_bin   <= m18p[35:31];
            o_yaw_bin     <= m18y[36:32];
            o_pitch_level <= 7'sd50 - 7'(m100p[38:31]);
            o_yaw_level   <= 7'(m100y[39:32]) - 7'sd50;
            o_roll_level  <= 7'(m100r[39:32]) - 7'sd50;
        end
    end

    logic r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    assign o_vld = r_v2;

endmodule

`default_nettype wire
